>>> src/websocket_frame_deframer_macros.svh
// Assertion macros shared by the checker files of the frame deframer.
// No dependencies; the including file supplies i_clk and i_rst_n.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define WSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked only out of reset.
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication that is also checked across reset.
`define WSD_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

>>> src/wsd_pkg.sv
// Types and constants of the frame deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package wsd_pkg;

    // Header field constants
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASKKEY = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    // One classified byte, passed from the parser to the output stage
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       payload;
        logic       frame_end;
        logic       close;
        logic [3:0] opcode;
    } t_cmd;

endpackage

>>> src/wsd_fifo.sv
// Small register queue between the header parser and the output stage.
// Depends on wsd_pkg (t_cmd).
`timescale 1ns / 1ps

module wsd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wsd_pkg::t_cmd i_wr_cmd,
    input  logic          i_pop,
    output wsd_pkg::t_cmd o_rd_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wsd_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

>>> src/wsd_front.sv
// Header parser: takes stream bytes, tracks frame phase and classifies each byte.
// Depends on wsd_pkg (t_phase, t_cmd, header constants).
`timescale 1ns / 1ps

module wsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_in_byte,
    input  logic          i_full,
    output logic          o_push,
    output wsd_pkg::t_cmd o_cmd
);

    wsd_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_opcode, n_opcode;
    logic            r_mask, n_mask;
    logic [63:0]     r_len, n_len;
    logic [2:0]      r_fbl, n_fbl;
    logic [3:0][7:0] r_key, n_key;
    logic [1:0]      r_idx, n_idx;

    logic fire;
    logic len_done;
    logic key_done;
    logic mask_now;
    logic enter;

    // no transfer while in reset
    assign o_in_ready = i_rst_n && !i_full;
    assign fire       = i_in_valid && o_in_ready;
    assign o_push     = fire;

    // Next state and classification of the current byte
    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_len    = r_len;
        n_fbl    = r_fbl;
        n_key    = r_key;
        n_idx    = r_idx;
        len_done = 1'b0;
        key_done = 1'b0;
        mask_now = r_mask;

        o_cmd           = '0;
        o_cmd.data      = i_in_byte;

        case (r_phase)
            wsd_pkg::PH_HDR1: begin
                n_mask   = i_in_byte[7];
                mask_now = i_in_byte[7];
                if (i_in_byte[6:0] == wsd_pkg::LEN_EXT16) begin
                    n_len   = '0;
                    n_fbl   = 3'd1;
                    n_phase = wsd_pkg::PH_EXTLEN;
                end else if (i_in_byte[6:0] == wsd_pkg::LEN_EXT64) begin
                    n_len   = '0;
                    n_fbl   = 3'd7;
                    n_phase = wsd_pkg::PH_EXTLEN;
                end else begin
                    n_len    = {57'd0, i_in_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            wsd_pkg::PH_EXTLEN: begin
                n_len = {r_len[55:0], i_in_byte};
                if (r_fbl == 3'd0) begin
                    len_done = 1'b1;
                end else begin
                    n_fbl = r_fbl - 3'd1;
                end
            end
            wsd_pkg::PH_MASKKEY: begin
                n_key = {r_key[2:0], i_in_byte};
                if (r_fbl == 3'd0) begin
                    key_done = 1'b1;
                end else begin
                    n_fbl = r_fbl - 3'd1;
                end
            end
            wsd_pkg::PH_PAYLOAD: begin
                // key byte 0 sits in the top byte of the key word
                o_cmd.key     = r_mask ? r_key[~r_idx] : 8'd0;
                o_cmd.payload = 1'b1;
                n_idx         = r_idx + 2'd1;
                n_len         = r_len - 64'd1;
                if (r_len == 64'd1) begin
                    o_cmd.frame_end = 1'b1;
                    o_cmd.close     = (r_opcode == wsd_pkg::OPC_CLOSE);
                    n_phase         = wsd_pkg::PH_HDR0;
                end
            end
            default: begin
                n_opcode = i_in_byte[3:0];
                n_phase  = wsd_pkg::PH_HDR1;
            end
        endcase

        // Length known: mask key next, or straight to payload
        if (len_done && mask_now) begin
            n_fbl   = 3'd3;
            n_key   = '0;
            n_phase = wsd_pkg::PH_MASKKEY;
        end

        // Header complete: a zero-length frame ends on this byte
        enter = key_done || (len_done && !mask_now);
        if (enter) begin
            if (n_len == 64'd0) begin
                o_cmd.frame_end = 1'b1;
                o_cmd.close     = (r_opcode == wsd_pkg::OPC_CLOSE);
                n_phase         = wsd_pkg::PH_HDR0;
            end else begin
                n_idx   = 2'd0;
                n_phase = wsd_pkg::PH_PAYLOAD;
            end
        end

        o_cmd.opcode = n_opcode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsd_pkg::PH_HDR0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_len    <= '0;
            r_fbl    <= '0;
            r_key    <= '0;
            r_idx    <= '0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_len    <= n_len;
            r_fbl    <= n_fbl;
            r_key    <= n_key;
            r_idx    <= n_idx;
        end
    end

endmodule

>>> src/wsd_back.sv
// Output stage: unmasks queued bytes and holds the result register.
// Depends on wsd_pkg (t_cmd).
`timescale 1ns / 1ps

module wsd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  wsd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_payload_byte,
    output logic          o_payload_valid,
    output logic          o_frame_end,
    output logic          o_close_frame,
    output logic [3:0]    o_frame_opcode
);

    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_pvalid;
    logic       r_end;
    logic       r_close;
    logic [3:0] r_opcode;

    // Load a new result when the register is empty or being drained
    assign o_pop = !i_empty && (!r_valid || i_out_ready);

    // Unmask; non-payload bytes report zero
    assign n_byte = i_cmd.payload ? (i_cmd.data ^ i_cmd.key) : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte   <= n_byte;
            r_pvalid <= i_cmd.payload;
            r_end    <= i_cmd.frame_end;
            r_close  <= i_cmd.close;
            r_opcode <= i_cmd.opcode;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_payload_byte  = r_byte;
    assign o_payload_valid = r_pvalid;
    assign o_frame_end     = r_end;
    assign o_close_frame   = r_close;
    assign o_frame_opcode  = r_opcode;

endmodule

>>> src/websocket_frame_deframer.sv
// WebSocket (RFC 6455) receive-side frame deframer, one stream byte per transfer. Every
// accepted byte yields exactly one result: payload bytes come out unmasked with
// payload_valid set, header bytes come out with payload_valid clear and a zero byte,
// and the byte that completes a frame (the last payload byte, or the last header byte
// of a zero-length frame) carries frame_end, plus close_frame for opcode 8. The block
// sustains one byte per clock while the output is ready. The queue is written at the input
// transfer edge and the output register is loaded from the queue when the register is empty
// or being drained. The header parser's 64-bit length decrement and compare set the
// critical path. The queue of QUEUE_DEPTH entries lets input and output stall
// independently; input ready drops only in reset or when the queue is full.
// Depends on wsd_pkg, wsd_front, wsd_fifo and wsd_back.
`timescale 1ns / 1ps

module websocket_frame_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_payload_valid,
    output logic       o_frame_end,
    output logic       o_close_frame,
    output logic [3:0] o_frame_opcode
);

    wsd_pkg::t_cmd wr_cmd;
    wsd_pkg::t_cmd rd_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    // Header parser
    wsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (wr_cmd)
    );

    // Decoupling queue
    wsd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wr_cmd (wr_cmd),
        .i_pop    (pop),
        .o_rd_cmd (rd_cmd),
        .o_full   (full),
        .o_empty  (empty)
    );

    // Unmask and output register
    wsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_cmd           (rd_cmd),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_payload_byte  (o_payload_byte),
        .o_payload_valid (o_payload_valid),
        .o_frame_end     (o_frame_end),
        .o_close_frame   (o_close_frame),
        .o_frame_opcode  (o_frame_opcode)
    );

endmodule

>>> src/wsd_checker.sv
// Port-level checks of the frame deframer, attached by bind.
// Depends on websocket_frame_deframer_macros.svh and wsd_pkg.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_macros.svh"

module wsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_in_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_payload_byte,
    input logic       o_payload_valid,
    input logic       o_frame_end,
    input logic       o_close_frame,
    input logic [3:0] o_frame_opcode
);

    // A stalled result holds
    `WSD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_payload_byte) && $stable(o_frame_end) && $stable(o_frame_opcode))

    // A close flag only ever comes with a frame end of an opcode-8 frame
    `WSD_ASSERT_NOW(a_close_end, o_out_valid && o_close_frame, o_frame_end && (o_frame_opcode == wsd_pkg::OPC_CLOSE))

    // Header bytes report a zero data byte
    `WSD_ASSERT_NOW(a_hdr_zero, o_out_valid && !o_payload_valid, o_payload_byte == 8'd0)

    // Nothing is shown in the cycle after reset
    `WSD_ASSERT_ALWAYS(a_rst_idle, !i_rst_n, !o_out_valid)

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
